@@ rtl/hrck_pkg.sv @@
// Shared types and constants for the hue range chroma key core.
// No dependencies; used by hrck_div_stage and hue_range_chroma_key_core.
`timescale 1ns / 1ps
`default_nettype none

package hrck_pkg;

    // Channel and hue widths
    localparam int CHAN_W     = 6;
    localparam int HUE_W      = 15;
    localparam int NUM_W      = 21;           // scaled hue numerator, < 23040 * 63
    localparam int CFG_ADDR_W = 1;

    // Hue scale: degrees times 64
    localparam int HUE_UNIT = 3840;           // 60 degrees
    localparam int HUE_FULL = 23040;          // 360 degrees

    // Divider layout: one quotient bit per step
    localparam int DIV_STEPS     = 3;
    localparam int DIV_STAGE_CNT = HUE_W / DIV_STEPS;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_HUE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_HUE = 1'd1;

    // Which channel holds the maximum
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pix_t;

    // Payload carried through the divider stages
    typedef struct packed {
        pix_t              pix;
        logic              has_hue;
        logic [CHAN_W-1:0] dvsr;      // delta, the divisor
        logic [CHAN_W-1:0] rem;       // partial remainder, always below dvsr
        logic [HUE_W-1:0]  quo;       // low dividend bits out, quotient bits in
    } div_pay_t;

endpackage

`default_nettype wire

@@ rtl/hrck_div_stage.sv @@
// One pipelined restoring-division stage: DIV_STEPS quotient bits per cycle while out_ready lets it advance.
// Depends on hrck_pkg (div_pay_t, DIV_STEPS, CHAN_W).
`timescale 1ns / 1ps
`default_nettype none

module hrck_div_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hrck_pkg::div_pay_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hrck_pkg::div_pay_t     out_data
);

    logic               valid_reg;
    hrck_pkg::div_pay_t data_reg;
    hrck_pkg::div_pay_t data_next;

    // Stage takes a transaction when empty or when its content moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Shift-subtract steps, most significant dividend bit first
    always_comb
    begin
        logic [hrck_pkg::CHAN_W:0] trial;
        logic                      ge;
        data_next = in_data;
        for (int k = 0; k < hrck_pkg::DIV_STEPS; k++)
        begin
            trial = {data_next.rem, data_next.quo[hrck_pkg::HUE_W-1]};
            ge    = (trial >= {1'b0, data_next.dvsr});
            if (ge)
            begin
                trial = trial - {1'b0, data_next.dvsr};
            end
            data_next.rem = trial[hrck_pkg::CHAN_W-1:0];
            data_next.quo = {data_next.quo[hrck_pkg::HUE_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hue_range_chroma_key_core.sv @@
// Pipeline: max/min register, numerator register,
// five divider stages of 3 quotient bits each, key/output register.
// Throughput: one pixel per cycle; every stage has its own valid and holds
// its content under backpressure, bubbles are squeezed out.
// Reset: rst_n asynchronous, active low; clears stage valids and sets both hue
// bounds to 0. Depends on hrck_pkg and hrck_div_stage.
`timescale 1ns / 1ps
`default_nettype none

module hue_range_chroma_key_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [hrck_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [hrck_pkg::HUE_W-1:0]      cfg_wdata,
    // Pixel in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red[5:0], green[11:6], blue[17:12], zero
    // Pixel out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // out_red[5:0], out_green[11:6],
                                             // out_blue[17:12], opaque[18], zero
);

    localparam int CW = hrck_pkg::CHAN_W;
    localparam int NS = hrck_pkg::DIV_STAGE_CNT;

    // Configuration registers
    logic [hrck_pkg::HUE_W-1:0] min_hue_reg;
    logic [hrck_pkg::HUE_W-1:0] max_hue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hue_reg <= '0;
            max_hue_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                hrck_pkg::CFG_MIN_HUE: min_hue_reg <= cfg_wdata;
                hrck_pkg::CFG_MAX_HUE: max_hue_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: max, min, delta, sector and signed difference
    // ------------------------------------------------------------------
    hrck_pkg::pix_t    in_pix;
    logic [CW-1:0]     mx;
    logic [CW-1:0]     mn;
    logic [1:0]        sec_next;
    logic signed [CW:0] diff_next;

    logic              s1_valid_reg;
    logic              s1_ready;
    hrck_pkg::pix_t    s1_pix_reg;
    logic [CW-1:0]     s1_d_reg;
    logic [1:0]        s1_sec_reg;
    logic signed [CW:0] s1_diff_reg;

    assign in_pix.red   = s_axis_tdata[CW-1:0];
    assign in_pix.green = s_axis_tdata[2*CW-1:CW];
    assign in_pix.blue  = s_axis_tdata[3*CW-1:2*CW];

    always_comb
    begin
        mx = in_pix.red;
        mn = in_pix.red;
        if (in_pix.green > mx) mx = in_pix.green;
        if (in_pix.blue  > mx) mx = in_pix.blue;
        if (in_pix.green < mn) mn = in_pix.green;
        if (in_pix.blue  < mn) mn = in_pix.blue;
        // red wins ties, then green
        if (in_pix.red == mx)
        begin
            sec_next  = hrck_pkg::SEC_RED;
            diff_next = $signed({1'b0, in_pix.green}) - $signed({1'b0, in_pix.blue});
        end
        else if (in_pix.green == mx)
        begin
            sec_next  = hrck_pkg::SEC_GREEN;
            diff_next = $signed({1'b0, in_pix.blue}) - $signed({1'b0, in_pix.red});
        end
        else
        begin
            sec_next  = hrck_pkg::SEC_BLUE;
            diff_next = $signed({1'b0, in_pix.red}) - $signed({1'b0, in_pix.green});
        end
    end

    assign s_axis_tready = !s1_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_pix_reg  <= in_pix;
            s1_d_reg    <= mx - mn;
            s1_sec_reg  <= sec_next;
            s1_diff_reg <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerator 3840*(2*sector*d + diff), wrapped by 23040*d if negative
    // ------------------------------------------------------------------
    logic signed [9:0]  x_val;
    logic signed [9:0]  d_s;
    logic signed [22:0] prod;
    logic signed [22:0] wrap;
    logic signed [22:0] num_full;
    hrck_pkg::div_pay_t s2_next;

    logic               s2_valid_reg;
    hrck_pkg::div_pay_t s2_data_reg;

    logic               dv_valid [0:NS];
    logic               dv_ready [0:NS];
    hrck_pkg::div_pay_t dv_data  [0:NS];

    assign d_s = $signed({4'b0, s1_d_reg});

    always_comb
    begin
        case (s1_sec_reg)
            hrck_pkg::SEC_GREEN: x_val = (d_s <<< 1) + 10'(s1_diff_reg);
            hrck_pkg::SEC_BLUE:  x_val = (d_s <<< 2) + 10'(s1_diff_reg);
            default:             x_val = 10'(s1_diff_reg);
        endcase
        prod     = 23'(x_val) * 23'sd3840;
        wrap     = $signed({17'b0, s1_d_reg}) * 23'sd23040;
        num_full = x_val[9] ? (prod + wrap) : prod;

        s2_next.pix     = s1_pix_reg;
        s2_next.has_hue = (s1_d_reg != '0);
        s2_next.dvsr    = s1_d_reg;
        // numerator < 2^15 * d, so its top bits are already a valid remainder
        s2_next.rem     = num_full[hrck_pkg::NUM_W-1:hrck_pkg::HUE_W];
        s2_next.quo     = num_full[hrck_pkg::HUE_W-1:0];
    end

    assign s1_ready = !s2_valid_reg || dv_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: hue64 = numerator / delta
    // ------------------------------------------------------------------
    assign dv_valid[0] = s2_valid_reg;
    assign dv_data[0]  = s2_data_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_div
        hrck_div_stage u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_data   (dv_data[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_data  (dv_data[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Key decision and output register
    // ------------------------------------------------------------------
    hrck_pkg::div_pay_t fin;
    logic               keyed;
    logic               out_valid_reg;
    logic [23:0]        out_data_reg;
    logic [23:0]        out_data_next;

    assign fin   = dv_data[NS];
    assign keyed = fin.has_hue && (fin.quo > min_hue_reg) && (fin.quo < max_hue_reg);

    always_comb
    begin
        out_data_next = '0;
        if (!keyed)
        begin
            out_data_next[CW-1:0]      = fin.pix.red;
            out_data_next[2*CW-1:CW]   = fin.pix.green;
            out_data_next[3*CW-1:2*CW] = fin.pix.blue;
            out_data_next[3*CW]        = 1'b1;
        end
    end

    assign dv_ready[NS] = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dv_ready[NS])
        begin
            out_valid_reg <= dv_valid[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready[NS] && dv_valid[NS])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
